// ----- rtl/kvpv_pkg.sv -----
`timescale 1ns / 1ps
// kvpv_pkg: types, constants and codes of the kv page view builder
// used by every file of the block, depends on nothing

package kvpv_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int MAX_SELECTED  = 64;
  localparam int PAGE_CELLS    = 256;  // power of two

  localparam int REC_CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int ACC_CNT_W = $clog2(MAX_SELECTED + 1);

  localparam logic [31:0] WORD_ONES = 32'hFFFF_FFFF;

  localparam logic [1:0] ACT_APPEND  = 2'd0;
  localparam logic [1:0] ACT_SELECT  = 2'd1;
  localparam logic [1:0] ACT_CLEAR   = 2'd2;
  localparam logic [1:0] ACT_UNKNOWN = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_NOT_RES  = 3'd3;
  localparam logic [2:0] ST_RANGE    = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;

  localparam logic [1:0] CFG_EPOCH  = 2'd0;
  localparam logic [1:0] CFG_FILTER = 2'd1;
  localparam logic [1:0] CFG_MASK   = 2'd2;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_FINISH
  } fsm_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [31:0]        page_no;
    logic signed [31:0] record_sequence;
    logic [31:0]        record_slot;
    logic [2:0]         record_state;
    logic signed [31:0] record_pos_begin;
    logic signed [31:0] record_pos_end;
    logic               last_selected;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [31:0]        src_slot;
    logic [31:0]        row_begin;
    logic [8:0]         row_cnt;
    logic signed [31:0] native_begin;
    logic signed [31:0] native_end;
    logic [31:0]        total_rows;
    logic               view_done;
  } out_item_t;

  typedef struct packed {
    logic [31:0] page;
    logic [31:0] seq;
    logic [31:0] slot;
    logic [2:0]  state;
    logic [31:0] pbeg;
    logic [31:0] pend;
  } rec_t;

  typedef struct packed {
    logic        any_seq;
    logic [31:0] seq;
  } filt_t;

  typedef struct packed {
    logic        valid;
    logic        found;
    logic [31:0] page;
    rec_t        hit;
  } rec_tok_t;

  typedef struct packed {
    logic        valid;
    logic        dup;
    logic [31:0] page;
  } acc_tok_t;

endpackage

// ----- rtl/kv_page_view_builder_top.sv -----
`timescale 1ns / 1ps
// kv_page_view_builder_top: top level, control, view state and result register
// depends on kvpv_pkg, kvpv_rec_cell and kvpv_acc_cell

// Append, clear and unknown requests need no chain scan; their result is
// registered at once. A select request runs a lookup token down two chains
// of cells, the record table (TABLE_ENTRIES cells) and the accepted page list
// (MAX_SELECTED cells), one cell per cycle; the request ends once both tokens
// have left their chains, so the longer chain sets its length, and it waits
// for a free result register. Only one request is in flight; a new one is
// taken once the block is idle and the result register is free. The config
// port is always ready and must only be written while the block is idle.
// Record table entries come with no reset, only the record count clears.

module kv_page_view_builder_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  kvpv_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output kvpv_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_data
);

  localparam int NT = kvpv_pkg::TABLE_ENTRIES;
  localparam int NA = kvpv_pkg::MAX_SELECTED;
  localparam int RW = kvpv_pkg::REC_CNT_W;
  localparam int AW = kvpv_pkg::ACC_CNT_W;

  // configuration registers
  logic [63:0] epoch_r;
  logic [31:0] filter_r;
  logic [7:0]  mask_r;

  // control and view state
  kvpv_pkg::fsm_t      state_r, state_nxt;
  logic [RW-1:0]       rec_count_r;
  logic [AW-1:0]       acc_count_r;
  logic [31:0]         rows_r;
  logic [2:0]          sticky_r;
  logic [31:0]         q_page_r;
  logic                q_last_r;
  logic                rec_got_r, acc_got_r;
  kvpv_pkg::rec_tok_t  rec_res_r;
  logic                dup_r;
  logic                out_valid_r;
  kvpv_pkg::out_item_t out_r;
  kvpv_pkg::out_item_t out_nxt;

  logic in_acc, out_free, launch, finish;
  logic is_sel;

  kvpv_pkg::rec_tok_t rec_tok [NT+1];
  kvpv_pkg::acc_tok_t acc_tok [NA+1];
  logic               acc_wr;
  kvpv_pkg::filt_t    filt;
  kvpv_pkg::rec_t     wr_rec;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign is_sel    = (in_data.action == kvpv_pkg::ACT_SELECT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r  <= 64'd0;
      filter_r <= 32'hFFFF_FFFF;
      mask_r   <= 8'd7;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        kvpv_pkg::CFG_EPOCH:  epoch_r  <= cfg_data;
        kvpv_pkg::CFG_FILTER: filter_r <= cfg_data[31:0];
        kvpv_pkg::CFG_MASK:   mask_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kvpv_pkg::FSM_IDLE:   if (in_acc && is_sel) state_nxt = kvpv_pkg::FSM_SCAN;
      kvpv_pkg::FSM_SCAN:   if (rec_got_r && acc_got_r) state_nxt = kvpv_pkg::FSM_FINISH;
      kvpv_pkg::FSM_FINISH: if (out_free) state_nxt = kvpv_pkg::FSM_IDLE;
      default:              state_nxt = kvpv_pkg::FSM_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall = 1'b1;
    finish   = 1'b0;
    unique case (state_r)
      kvpv_pkg::FSM_IDLE:   in_stall = !out_free;
      kvpv_pkg::FSM_SCAN:   in_stall = 1'b1;
      kvpv_pkg::FSM_FINISH: finish   = out_free;
      default:              in_stall = 1'b1;
    endcase
  end

  assign launch = in_acc && is_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kvpv_pkg::FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // token injection into both chains
  assign filt = '{any_seq: filter_r[31], seq: filter_r};

  assign wr_rec = '{page:  in_data.page_no,
                    seq:   in_data.record_sequence,
                    slot:  in_data.record_slot,
                    state: in_data.record_state,
                    pbeg:  in_data.record_pos_begin,
                    pend:  in_data.record_pos_end};

  assign rec_tok[0] = '{valid: launch, found: 1'b0, page: in_data.page_no, hit: '0};
  assign acc_tok[0] = '{valid: launch, dup: 1'b0, page: in_data.page_no};

  for (genvar i = 0; i < NT; i++) begin : g_rec
    kvpv_rec_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .wr_en  (in_acc && (in_data.action == kvpv_pkg::ACT_APPEND) &&
               (rec_count_r == RW'(i))),
      .wr_rec (wr_rec),
      .live   (rec_count_r > RW'(i)),
      .filt   (filt),
      .tok_i  (rec_tok[i]),
      .tok_o  (rec_tok[i+1])
    );
  end

  for (genvar i = 0; i < NA; i++) begin : g_acc
    kvpv_acc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_en   (acc_wr && (acc_count_r == AW'(i))),
      .wr_page (q_page_r),
      .live    (acc_count_r > AW'(i)),
      .tok_i   (acc_tok[i]),
      .tok_o   (acc_tok[i+1])
    );
  end

  // catch the tokens leaving the chain ends
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_got_r <= 1'b0;
      acc_got_r <= 1'b0;
    end else if (launch) begin
      rec_got_r <= 1'b0;
      acc_got_r <= 1'b0;
    end else begin
      if (rec_tok[NT].valid) rec_got_r <= 1'b1;
      if (acc_tok[NA].valid) acc_got_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (launch) begin
      q_page_r <= in_data.page_no;
      q_last_r <= in_data.last_selected;
    end
    if (rec_tok[NT].valid) rec_res_r <= rec_tok[NT];
    if (acc_tok[NA].valid) dup_r <= acc_tok[NA].dup;
  end

  // selection checks, in priority order
  logic signed [32:0] b_s, e_s, cnt_s;
  logic [33:0]        rows_sum;
  logic [2:0]         sel_st;
  logic [31:0]        rows_new;

  assign b_s      = {rec_res_r.hit.pbeg[31], rec_res_r.hit.pbeg};
  assign e_s      = {rec_res_r.hit.pend[31], rec_res_r.hit.pend};
  assign cnt_s    = e_s - b_s;
  assign rows_sum = {2'b00, rows_r} + {1'b0, cnt_s};

  always_comb begin
    if (sticky_r != kvpv_pkg::ST_OK) begin
      sel_st = sticky_r;
    end else if (epoch_r == 64'd0) begin
      sel_st = kvpv_pkg::ST_INVALID;
    end else if (!rec_res_r.found) begin
      sel_st = kvpv_pkg::ST_NOT_RES;
    end else if (dup_r) begin
      sel_st = kvpv_pkg::ST_DUP;
    end else if ((rec_res_r.hit.slot == kvpv_pkg::WORD_ONES) ||
                 !mask_r[rec_res_r.hit.state]) begin
      sel_st = kvpv_pkg::ST_NOT_RES;
    end else if (b_s[32] || (e_s <= b_s)) begin
      sel_st = kvpv_pkg::ST_RANGE;
    end else if (((rec_res_r.hit.pbeg % kvpv_pkg::PAGE_CELLS) != 32'd0) ||
                 (q_page_r != (rec_res_r.hit.pbeg / kvpv_pkg::PAGE_CELLS)) ||
                 (cnt_s > 33'(kvpv_pkg::PAGE_CELLS))) begin
      sel_st = kvpv_pkg::ST_RANGE;
    end else if (rows_sum > {2'b00, kvpv_pkg::WORD_ONES}) begin
      sel_st = kvpv_pkg::ST_OVERFLOW;
    end else if (acc_count_r >= AW'(NA)) begin
      sel_st = kvpv_pkg::ST_OVERFLOW;
    end else begin
      sel_st = kvpv_pkg::ST_OK;
    end
  end

  assign acc_wr   = finish && (sel_st == kvpv_pkg::ST_OK);
  assign rows_new = acc_wr ? rows_sum[31:0] : rows_r;

  // view state and record count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_count_r <= '0;
      acc_count_r <= '0;
      rows_r      <= 32'd0;
      sticky_r    <= kvpv_pkg::ST_OK;
    end else begin
      if (in_acc && (in_data.action == kvpv_pkg::ACT_APPEND) && (rec_count_r < RW'(NT))) begin
        rec_count_r <= rec_count_r + RW'(1);
      end else if (in_acc && (in_data.action == kvpv_pkg::ACT_CLEAR)) begin
        rec_count_r <= '0;
      end
      if (finish) begin
        if (q_last_r) begin
          acc_count_r <= '0;
          rows_r      <= 32'd0;
          sticky_r    <= kvpv_pkg::ST_OK;
        end else begin
          if (acc_wr) acc_count_r <= acc_count_r + AW'(1);
          rows_r   <= rows_new;
          sticky_r <= sel_st;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((in_acc && !is_sel) || finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    out_nxt = '0;
    if (finish) begin
      out_nxt.total_rows = rows_new;
      out_nxt.view_done  = q_last_r;
      if (acc_wr && (rows_new != 32'd0 || !q_last_r)) begin
        out_nxt.status       = kvpv_pkg::ST_OK;
        out_nxt.src_slot     = rec_res_r.hit.slot;
        out_nxt.row_begin    = rows_r;
        out_nxt.row_cnt      = cnt_s[8:0];
        out_nxt.native_begin = rec_res_r.hit.pbeg;
        out_nxt.native_end   = rec_res_r.hit.pend;
      end else if (acc_wr) begin
        out_nxt.status = kvpv_pkg::ST_OVERFLOW;  // empty view on close
      end else begin
        out_nxt.status = sel_st;
      end
    end else begin
      case (in_data.action)
        kvpv_pkg::ACT_APPEND:
          out_nxt.status = (rec_count_r < RW'(NT)) ? kvpv_pkg::ST_OK : kvpv_pkg::ST_OVERFLOW;
        kvpv_pkg::ACT_CLEAR:   out_nxt.status = kvpv_pkg::ST_OK;
        default:               out_nxt.status = kvpv_pkg::ST_INVALID;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (finish || (in_acc && !is_sel)) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != kvpv_pkg::FSM_IDLE) |-> in_stall)
    else $error("request taken while a selection is in flight");
  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    acc_count_r <= AW'(NA))
    else $error("accepted page count beyond list size");
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_r)))
    else $error("stalled result lost or changed");
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    finish |-> out_free)
    else $error("selection finished into a busy result register");
`endif

endmodule

// ----- rtl/kvpv_rec_cell.sv -----
`timescale 1ns / 1ps
// kvpv_rec_cell: one record of the resident table and one stage of the lookup chain
// depends on kvpv_pkg

module kvpv_rec_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  kvpv_pkg::rec_t    wr_rec,
  input  logic              live,
  input  kvpv_pkg::filt_t   filt,
  input  kvpv_pkg::rec_tok_t tok_i,
  output kvpv_pkg::rec_tok_t tok_o
);

  kvpv_pkg::rec_t     rec_r;
  kvpv_pkg::rec_tok_t tok_r;
  kvpv_pkg::rec_tok_t tok_nxt;
  logic               hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rec_r <= wr_rec;
    end
  end

  // first match wins: an already found token passes untouched
  assign hit = tok_i.valid && !tok_i.found && live && (rec_r.page == tok_i.page) &&
               (filt.any_seq || (rec_r.seq == filt.seq));

  always_comb begin
    tok_nxt = tok_i;
    if (hit) begin
      tok_nxt.found = 1'b1;
      tok_nxt.hit   = rec_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.found <= tok_nxt.found;
    tok_r.page  <= tok_nxt.page;
    tok_r.hit   <= tok_nxt.hit;
  end

  assign tok_o = tok_r;

endmodule

// ----- rtl/kvpv_acc_cell.sv -----
`timescale 1ns / 1ps
// kvpv_acc_cell: one accepted page of the view and one stage of the duplicate chain
// depends on kvpv_pkg

module kvpv_acc_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [31:0]        wr_page,
  input  logic               live,
  input  kvpv_pkg::acc_tok_t tok_i,
  output kvpv_pkg::acc_tok_t tok_o
);

  logic [31:0]        page_r;
  kvpv_pkg::acc_tok_t tok_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      page_r <= wr_page;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_i.valid;
    end
    tok_r.page <= tok_i.page;
    tok_r.dup  <= tok_i.dup || (tok_i.valid && live && (page_r == tok_i.page));
  end

  assign tok_o = tok_r;

endmodule
